FILE: rtl/core/assert_macros.svh
// Assertion helpers, compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication under reset.
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication under reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

FILE: rtl/core/spdkf_pkg.sv
package spdkf_pkg;

    localparam int COUNT_WIDTH_DEF = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT_DIR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT  = 3'd4;

    localparam logic [23:0] SPEED_SCALE_RST   = 24'd13726;
    localparam logic [30:0] PROCESS_NOISE_RST = 31'd1073742;
    localparam logic [31:0] MEAS_NOISE_RST    = 32'd53687091;
    localparam logic [30:0] SPEED_LIMIT_RST   = 31'd104858;

    // 1.0 in Q2.30
    localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
    localparam logic [62:0] HALF_Q30 = 63'h2000_0000;

    // Quotient bits of the gain division
    localparam int GAIN_W    = 31;
    localparam int DIV_CNT_W = 5;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = 5'(GAIN_W - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_RAW,
        ST_SAT_RAW,
        ST_DIV,
        ST_INNOV,
        ST_MUL_EST,
        ST_UPD_EST,
        ST_UPD_VAR,
        ST_OUT
    } state_t;

endpackage

FILE: rtl/core/encoder_speed_kalman_estimator.sv
// Encoder speed estimator with a scalar Kalman filter.
// Input channel (s_valid/s_ready): one signed encoder count delta per control
// period. Result channel (m_valid/m_ready): filtered speed in 2^-20 m/s,
// clamped to +/- speed_limit, with m_clamped set when the clamp acted.
// Configuration: write cfg_wdata to register cfg_addr while cfg_we is high;
// 0 speed_scale, 1 invert_direction, 2 process_noise, 3 measurement_noise,
// 4 speed_limit. Other indexes are ignored.
// One request is in flight at a time; s_ready returns the cycle after
// the result is loaded. The 31-step restoring divider forms the gain
// K = P/(P+R); one shared multiplier serves raw speed, estimate update
// and variance update.
// A finished result sits in the output register; the next request is taken
// while it waits, but its result holds in the last step until m_ready frees
// the register. Reset clears the estimate to 0, the variance to 1.0 and
// loads the default register values.
`include "assert_macros.svh"

module encoder_speed_kalman_estimator
    import spdkf_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [CFG_IDX_W-1:0]          cfg_addr,
    input  logic [CFG_DATA_W-1:0]         cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COUNT_WIDTH-1:0] s_encoder_count,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [31:0]            m_speed,
    output logic                          m_clamped
);

    localparam int MAG_W   = COUNT_WIDTH + 1;
    localparam int MUL_A_W = (MAG_W > 32) ? MAG_W : 32;
    localparam int PROD_W  = MUL_A_W + 32;

    // Configuration registers
    logic [23:0] speed_scale_reg;
    logic        invert_reg;
    logic [30:0] process_noise_reg;
    logic [31:0] meas_noise_reg;
    logic [30:0] speed_limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_scale_reg   <= SPEED_SCALE_RST;
            invert_reg        <= 1'b0;
            process_noise_reg <= PROCESS_NOISE_RST;
            meas_noise_reg    <= MEAS_NOISE_RST;
            speed_limit_reg   <= SPEED_LIMIT_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_SPEED_SCALE:   speed_scale_reg   <= cfg_wdata[23:0];
                REG_INVERT_DIR:    invert_reg        <= cfg_wdata[0];
                REG_PROCESS_NOISE: process_noise_reg <= cfg_wdata[30:0];
                REG_MEAS_NOISE:    meas_noise_reg    <= cfg_wdata[31:0];
                REG_SPEED_LIMIT:   speed_limit_reg   <= cfg_wdata[30:0];
                default: ;
            endcase
        end
    end

    // Sequencer
    state_t state_reg, state_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic out_free;
    logic m_valid_reg;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (s_valid) state_next = ST_MUL_RAW;
            ST_MUL_RAW: state_next = ST_SAT_RAW;
            ST_SAT_RAW: state_next = ST_DIV;
            ST_DIV:     if (div_cnt_reg == DIV_LAST) state_next = ST_INNOV;
            ST_INNOV:   state_next = ST_MUL_EST;
            ST_MUL_EST: state_next = ST_UPD_EST;
            ST_UPD_EST: state_next = ST_UPD_VAR;
            ST_UPD_VAR: state_next = ST_OUT;
            ST_OUT:     if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Control outputs and multiplier operand select
    logic [MAG_W-1:0]   count_mag_reg;
    logic [31:0]        innov_mag_reg;
    logic [GAIN_W-1:0]  gain_reg;
    logic [31:0]        p_reg;
    logic [MUL_A_W-1:0] mul_a;
    logic [31:0]        mul_b;
    logic               load_out;

    always_comb begin
        s_ready  = 1'b0;
        load_out = 1'b0;
        mul_a    = MUL_A_W'(innov_mag_reg);
        mul_b    = 32'(gain_reg);
        case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_MUL_RAW: begin
                mul_a = MUL_A_W'(count_mag_reg);
                mul_b = 32'(speed_scale_reg);
            end
            ST_UPD_EST: begin
                mul_a = MUL_A_W'(ONE_Q30 - gain_reg);
                mul_b = p_reg;
            end
            ST_OUT: load_out = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Shared multiplier, registered product
    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // Input capture: sign and magnitude of the (optionally negated) count
    logic [MAG_W-1:0] cnt_ext;
    logic [MAG_W-1:0] cnt_abs;
    logic             count_neg_reg;

    assign cnt_ext = {s_encoder_count[COUNT_WIDTH-1], s_encoder_count};
    assign cnt_abs = cnt_ext[MAG_W-1] ? (~cnt_ext + MAG_W'(1)) : cnt_ext;

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            count_mag_reg <= cnt_abs;
            count_neg_reg <= cnt_ext[MAG_W-1] ^ invert_reg;
        end
    end

    // Datapath
    logic [32:0] p_sum;
    logic [31:0] p_next;
    logic signed [31:0] raw_reg;
    logic signed [31:0] raw_next;
    logic [32:0] denom_reg;
    logic [32:0] rem_reg;
    logic [33:0] rem_shift;
    logic        div_ge;
    logic [32:0] rem_next;
    logic [GAIN_W-1:0] quo_reg;
    logic signed [32:0] innov;
    logic        innov_neg_reg;
    logic [62:0] delta_sum;
    logic [32:0] delta;
    logic signed [33:0] est_wide;
    logic signed [31:0] est_next;
    logic signed [31:0] est_reg;
    logic [31:0] variance_reg;

    assign p_sum  = 33'(variance_reg) + 33'(process_noise_reg);
    assign p_next = p_sum[32] ? 32'hFFFF_FFFF : p_sum[31:0];

    always_comb begin
        if (count_neg_reg) begin
            raw_next = (prod_reg > PROD_W'(33'h0_8000_0000)) ? 32'sh8000_0000
                     : 32'(~prod_reg[31:0] + 32'd1);
        end else begin
            raw_next = (prod_reg > PROD_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                     : signed'(prod_reg[31:0]);
        end
    end

    // Restoring division step; the dividend's low bit enters first, then zeros
    assign rem_shift = {rem_reg, (div_cnt_reg == '0) ? p_reg[0] : 1'b0};
    assign div_ge    = rem_shift >= {1'b0, denom_reg};
    assign rem_next  = div_ge ? 33'(rem_shift - {1'b0, denom_reg}) : rem_shift[32:0];

    assign innov = {raw_reg[31], raw_reg} - {est_reg[31], est_reg};

    // Round to nearest, ties away from zero, on the magnitude
    assign delta_sum = prod_reg[62:0] + HALF_Q30;
    assign delta     = delta_sum[62:30];
    assign est_wide  = innov_neg_reg ? ({{2{est_reg[31]}}, est_reg} - {1'b0, delta})
                                     : ({{2{est_reg[31]}}, est_reg} + {1'b0, delta});

    always_comb begin
        if (est_wide > 34'sh0_7FFF_FFFF) begin
            est_next = 32'sh7FFF_FFFF;
        end else if (est_wide < -34'sh0_8000_0000) begin
            est_next = 32'sh8000_0000;
        end else begin
            est_next = est_wide[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_MUL_RAW: p_reg <= p_next;
            ST_SAT_RAW: begin
                raw_reg   <= raw_next;
                denom_reg <= 33'(p_reg) + 33'(meas_noise_reg);
                rem_reg   <= 33'(p_reg[31:1]);
            end
            ST_DIV: begin
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[GAIN_W-2:0], div_ge};
            end
            ST_INNOV: begin
                // zero denominator: keep the estimate
                gain_reg      <= (denom_reg == '0) ? '0 : quo_reg;
                innov_neg_reg <= innov[32];
                innov_mag_reg <= innov[32] ? 32'(-innov) : innov[31:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg <= '0;
        end else if (state_reg == ST_DIV) begin
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
        end else begin
            div_cnt_reg <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            est_reg      <= '0;
            variance_reg <= {1'b0, ONE_Q30};
        end else begin
            if (state_reg == ST_UPD_EST) begin
                est_reg <= est_next;
            end
            if (state_reg == ST_UPD_VAR) begin
                variance_reg <= prod_reg[61:30];
            end
        end
    end

    // Output clamp and register
    logic signed [32:0] lim_s;
    logic signed [32:0] est_s;
    logic signed [31:0] speed_next;
    logic               clamped_next;
    logic signed [31:0] speed_reg;
    logic               clamped_reg;

    assign lim_s = signed'({2'b00, speed_limit_reg});
    assign est_s = signed'({est_reg[31], est_reg});

    always_comb begin
        speed_next   = est_reg;
        clamped_next = 1'b0;
        if (est_s > lim_s) begin
            speed_next   = signed'({1'b0, speed_limit_reg});
            clamped_next = 1'b1;
        end else if (est_s < -lim_s) begin
            speed_next   = 32'(-lim_s);
            clamped_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            speed_reg   <= speed_next;
            clamped_reg <= clamped_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_speed   = speed_reg;
    assign m_clamped = clamped_reg;

    `ASSERT_IMPL(a_gain_max, aclk, aresetn, state_reg == ST_MUL_EST, gain_reg <= ONE_Q30)
    `ASSERT_NEXT(a_var_shrinks, aclk, aresetn, state_reg == ST_UPD_VAR, variance_reg <= $past(p_reg))
    `ASSERT_IMPL(a_div_rem, aclk, aresetn, state_reg == ST_DIV && denom_reg != '0, rem_reg < denom_reg)

endmodule

FILE: sim/speed_estimate_monitor.sv
module speed_estimate_monitor
    import spdkf_pkg::*;
(
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [CFG_IDX_W-1:0]              cfg_addr,
    input  logic [CFG_DATA_W-1:0]             cfg_wdata,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic signed [COUNT_WIDTH_DEF-1:0] s_encoder_count,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic signed [31:0]                m_speed,
    input  logic                              m_clamped,
    output int                                result_count,
    output int                                fail_count,
    output int                                pending
);

    typedef struct packed {
        logic signed [31:0] speed;
        logic               clamped;
    } speed_result_t;

    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483647 - 64'sd1;
    localparam int     MAX_REPORTS = 10;

    speed_result_t expected_speeds[$];

    // Register shadow, tracked from the write port
    logic [23:0] scale;
    logic        invert;
    logic [30:0] q_noise;
    logic [31:0] r_noise;
    logic [30:0] limit;

    // Filter state: unclamped estimate and Q2.30 variance
    longint      est;
    logic [31:0] var_q;

    int n_results;
    int n_fail;

    function automatic longint sat32(input longint v);
        if (v > S32_MAX) return S32_MAX;
        if (v < S32_MIN) return S32_MIN;
        return v;
    endfunction

    function automatic speed_result_t filter_step(
        input logic signed [COUNT_WIDTH_DEF-1:0] cnt
    );
        longint        cnt_l;
        longint        raw;
        longint        innov;
        longint        lim;
        longint        res;
        logic [63:0]   p;
        logic [63:0]   denom;
        logic [63:0]   gain;
        logic [63:0]   mag;
        logic [63:0]   delta;
        speed_result_t r;

        cnt_l = longint'(cnt);
        if (invert) cnt_l = -cnt_l;
        raw = sat32(cnt_l * longint'(scale));

        // predict: P + Q, saturated to 32 bits
        p = {32'd0, var_q} + 64'(q_noise);
        if (p > 64'hFFFF_FFFF) p = 64'hFFFF_FFFF;

        denom = p + 64'(r_noise);
        gain = (denom == 64'd0) ? 64'd0 : (p << 30) / denom;

        // move toward the raw speed, rounding half away from zero
        innov = raw - est;
        mag = (innov < 0) ? 64'(-innov) : 64'(innov);
        delta = (mag * gain + 64'(HALF_Q30)) >> 30;
        if (innov < 0) est = est - longint'(delta);
        else           est = est + longint'(delta);
        est = sat32(est);

        var_q = 32'(((64'(ONE_Q30) - gain) * p) >> 30);

        lim = longint'(limit);
        res = est;
        r.clamped = 1'b0;
        if (res > lim) begin
            res = lim;
            r.clamped = 1'b1;
        end else if (res < -lim) begin
            res = -lim;
            r.clamped = 1'b1;
        end
        r.speed = 32'(res);
        return r;
    endfunction

    function automatic void note_failure(input speed_result_t want, input speed_result_t got,
                                         input bit orphan);
        n_fail++;
        if (n_fail <= MAX_REPORTS) begin
            if (orphan)
                $display("unexpected result: speed %0d clamped %0d", got.speed, got.clamped);
            else
                $display("mismatch on result %0d: expected speed %0d clamped %0d, got speed %0d clamped %0d",
                         n_results, want.speed, want.clamped, got.speed, got.clamped);
        end
    endfunction

    always @(posedge aclk) begin : watch
        speed_result_t got;
        speed_result_t want;

        if (!aresetn) begin
            scale   = SPEED_SCALE_RST;
            invert  = 1'b0;
            q_noise = PROCESS_NOISE_RST;
            r_noise = MEAS_NOISE_RST;
            limit   = SPEED_LIMIT_RST;
            est     = 0;
            var_q   = 32'(ONE_Q30);
            expected_speeds.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_SPEED_SCALE:   scale   = cfg_wdata[23:0];
                    REG_INVERT_DIR:    invert  = cfg_wdata[0];
                    REG_PROCESS_NOISE: q_noise = cfg_wdata[30:0];
                    REG_MEAS_NOISE:    r_noise = cfg_wdata;
                    REG_SPEED_LIMIT:   limit   = cfg_wdata[30:0];
                    default: ;
                endcase
            end
            // check the result before queueing a new request: a result
            // can never belong to a request taken at the same edge
            if (m_valid && m_ready) begin
                got.speed   = m_speed;
                got.clamped = m_clamped;
                n_results++;
                if (expected_speeds.size() == 0) begin
                    note_failure(got, got, 1'b1);
                end else begin
                    want = expected_speeds.pop_front();
                    if (want.speed !== got.speed || want.clamped !== got.clamped)
                        note_failure(want, got, 1'b0);
                end
            end
            if (s_valid && s_ready)
                expected_speeds.push_back(filter_step(s_encoder_count));
        end
        result_count <= n_results;
        fail_count   <= n_fail;
        pending      <= expected_speeds.size();
    end

endmodule

FILE: sim/encoder_speed_kalman_estimator_tb.sv
module encoder_speed_kalman_estimator_tb;
    import spdkf_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LAST  = 3'd7;
    localparam int NUM_PHASES     = 8;
    localparam int PHASE_ITEMS    = 50;
    localparam int DRAIN_CYCLES   = 50;

    logic                              aclk = 1'b0;
    logic                              aresetn = 1'b0;
    logic                              cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]              cfg_addr = REG_SPEED_SCALE;
    logic [CFG_DATA_W-1:0]             cfg_wdata = '0;
    logic                              s_valid = 1'b0;
    logic                              s_ready;
    logic signed [COUNT_WIDTH_DEF-1:0] s_encoder_count = '0;
    logic                              m_valid;
    logic                              m_ready = 1'b0;
    logic signed [31:0]                m_speed;
    logic                              m_clamped;

    int result_count;
    int fail_count;
    int pending;
    int sent_count = 0;
    int idle_pct = 0;
    int stall_pct = 0;

    int default_counts[8] = '{0, 32767, -32768, -32768, 1, -1, 5, -7};
    int wide_counts[4]    = '{-32768, 32767, 0, 12345};
    int zero_r_counts[3]  = '{100, 50, -3};

    encoder_speed_kalman_estimator i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_encoder_count (s_encoder_count),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_speed         (m_speed),
        .m_clamped       (m_clamped)
    );

    speed_estimate_monitor i_monitor (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_encoder_count (s_encoder_count),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_speed         (m_speed),
        .m_clamped       (m_clamped),
        .result_count    (result_count),
        .fail_count      (fail_count),
        .pending         (pending)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    // Junk above the width of each narrower register must be dropped by the block.
    task automatic load_config(input logic [23:0] scale, input logic inv, input logic [30:0] q,
                               input logic [31:0] r, input logic [30:0] lim);
        write_reg(REG_SPEED_SCALE, {8'($urandom), scale});
        write_reg(REG_INVERT_DIR, {31'($urandom), inv});
        write_reg(REG_PROCESS_NOISE, {1'($urandom), q});
        write_reg(REG_MEAS_NOISE, r);
        write_reg(REG_SPEED_LIMIT, {1'($urandom), lim});
        write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_LAST, REG_UNUSED_FIRST)), $urandom);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_count(input logic signed [COUNT_WIDTH_DEF-1:0] cnt);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_encoder_count <= cnt;
        do @(posedge aclk); while (!s_ready);
        sent_count++;
    endtask

    // Drop valid and hold until every request has its result.
    task automatic settle();
        s_valid <= 1'b0;
        while (result_count < sent_count) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 87; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 87; end
            default: begin idle_pct = 14; stall_pct = 14; end
        endcase
    endtask

    function automatic logic [31:0] pick_value(input logic [31:0] lo, input logic [31:0] hi);
        case ($urandom_range(5))
            0: return lo;
            1: return hi;
            default: return $urandom_range(hi, lo);
        endcase
    endfunction

    initial begin
        int base;
        int sel;
        logic signed [COUNT_WIDTH_DEF-1:0] cnt;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset register values: clamp on both sides, most negative count
        foreach (default_counts[k]) send_count(COUNT_WIDTH_DEF'(default_counts[k]));
        settle();

        // full scale with inversion: raw speed saturates both ways
        load_config(24'hFF_FFFF, 1'b1, 31'h4000_0000, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
        foreach (wide_counts[k]) send_count(COUNT_WIDTH_DEF'(wide_counts[k]));
        settle();

        // no noise: unit gain first, then a zero denominator keeps the estimate
        load_config(24'd1, 1'b0, 31'd0, 32'd0, 31'd0);
        foreach (zero_r_counts[k]) send_count(COUNT_WIDTH_DEF'(zero_r_counts[k]));
        settle();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            set_idling(phase % 4);
            load_config(24'(pick_value(32'd0, 32'hFF_FFFF)), 1'($urandom),
                        31'(pick_value(32'd0, 32'h4000_0000)),
                        pick_value(32'd1, 32'hFFFF_FFFF),
                        31'(pick_value(32'd0, 32'h7FFF_FFFF)));
            // steady wheel speed with jitter, plus noise and extremes
            base = int'($urandom_range(2000)) - 1000;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                sel = $urandom_range(99);
                if (sel < 75)
                    cnt = COUNT_WIDTH_DEF'(base + int'($urandom_range(40)) - 20);
                else if (sel < 95)
                    cnt = COUNT_WIDTH_DEF'($urandom);
                else
                    cnt = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
                send_count(cnt);
            end
            settle();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/spdkf_pkg.sv
rtl/core/encoder_speed_kalman_estimator.sv
sim/speed_estimate_monitor.sv
sim/encoder_speed_kalman_estimator_tb.sv
